// ===== hw/rtl/i2cms_pkg.sv =====
// Package for the I2C master line sequencer: command and step codes, status bundle, step decoder.
package i2cms_pkg;

  localparam int unsigned HoldW     = 16;
  localparam int unsigned PhaseW    = 5;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BitsPerB  = 8;
  localparam logic [HoldW-1:0] HOLD_RESET = 16'd5;

  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam logic [0:0] REG_HOLD_TICKS = 1'b0;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_SCL    = 2'd0,
    ACT_SDA    = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_END    = 2'd3
  } act_t;

  typedef struct packed {
    act_t act;
    logic lvl;
  } step_t;

  typedef struct packed {
    logic             tick;
    logic             cmd_valid;
    op_t              opcode;
    logic [ByteW-1:0] tx_byte;
    logic             send_ack;
    logic             sda_in;
  } tick_t;

  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx_byte;
    logic             ack_level;
  } status_t;

  // Action of step p for a command.
  function automatic step_t step_decode(op_t op, logic [PhaseW-1:0] p,
                                        logic [ByteW-1:0] sh, logic ackc);
    step_t s;
    s.act = ACT_END;
    s.lvl = 1'b0;
    unique case (op)
      OP_START: begin
        if (p == 5'd0) begin
          s.act = ACT_SDA; s.lvl = 1'b1;
        end else if (p == 5'd1) begin
          s.act = ACT_SCL; s.lvl = 1'b1;
        end else if (p == 5'd2) begin
          s.act = ACT_SDA;
        end else if (p == 5'd3) begin
          s.act = ACT_SCL;
        end
      end
      OP_STOP: begin
        if (p == 5'd0) begin
          s.act = ACT_SDA;
        end else if (p == 5'd1) begin
          s.act = ACT_SCL; s.lvl = 1'b1;
        end else if (p == 5'd2) begin
          s.act = ACT_SDA; s.lvl = 1'b1;
        end
      end
      OP_WRITE: begin
        for (int k = 0; k < BitsPerB; k++) begin
          if (p == PhaseW'(3 * k)) begin
            s.act = ACT_SDA; s.lvl = sh[BitsPerB-1-k];
          end
          if (p == PhaseW'(3 * k + 1)) begin
            s.act = ACT_SCL; s.lvl = 1'b1;
          end
          if (p == PhaseW'(3 * k + 2)) begin
            s.act = ACT_SCL;
          end
        end
        if (p == 5'd24) begin
          s.act = ACT_SDA; s.lvl = 1'b1;
        end else if (p == 5'd25) begin
          s.act = ACT_SCL; s.lvl = 1'b1;
        end else if (p == 5'd26) begin
          s.act = ACT_SAMPLE;
        end else if (p == 5'd27) begin
          s.act = ACT_SCL;
        end
      end
      OP_READ: begin
        if (p == 5'd0) begin
          s.act = ACT_SDA; s.lvl = 1'b1;
        end
        for (int k = 0; k < BitsPerB; k++) begin
          if (p == PhaseW'(3 * k + 1)) begin
            s.act = ACT_SCL; s.lvl = 1'b1;
          end
          if (p == PhaseW'(3 * k + 2)) begin
            s.act = ACT_SAMPLE;
          end
          if (p == PhaseW'(3 * k + 3)) begin
            s.act = ACT_SCL;
          end
        end
        if (p == 5'd25) begin
          s.act = ACT_SDA; s.lvl = ~ackc;
        end else if (p == 5'd26) begin
          s.act = ACT_SCL; s.lvl = 1'b1;
        end else if (p == 5'd27) begin
          s.act = ACT_SCL;
        end
      end
      default: s.act = ACT_END;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/i2cms_core.sv =====
// Sequencer core: command state, step counter, hold timer and line levels, advanced one tick per word.
module i2cms_core
  import i2cms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tick_t            tick_i,
  input  logic [HoldW-1:0] hold_ticks_i,
  output status_t          status_o
);

  op_t               op_r, op_nxt;
  logic              busy_r, busy_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [HoldW-1:0]  hold_cnt_r, hold_cnt_nxt;
  logic [ByteW-1:0]  shift_r, shift_nxt;
  logic              ack_choice_r, ack_choice_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic [ByteW-1:0]  rx_byte_r, rx_byte_nxt;
  logic              ack_level_r, ack_level_nxt;
  logic              done_r, done_nxt;

  logic [HoldW-1:0]  hold_eff;
  logic [HoldW-1:0]  hold_dec;
  logic [PhaseW-1:0] phase_inc;
  step_t             cur_step;
  step_t             new_step;

  assign hold_eff  = (hold_ticks_i == '0) ? HoldW'(1) : hold_ticks_i;
  assign hold_dec  = (hold_cnt_r != '0) ? hold_cnt_r - HoldW'(1) : hold_cnt_r;
  assign phase_inc = phase_r + PhaseW'(1);

  always_comb begin
    op_nxt         = op_r;
    busy_nxt       = busy_r;
    phase_nxt      = phase_r;
    hold_cnt_nxt   = hold_cnt_r;
    shift_nxt      = shift_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    rx_byte_nxt    = rx_byte_r;
    ack_level_nxt  = ack_level_r;
    done_nxt       = 1'b0;
    cur_step       = step_decode(op_r, phase_r, shift_r, ack_choice_r);
    new_step       = step_decode(tick_i.opcode, '0, tick_i.tx_byte, tick_i.send_ack);

    if (!busy_r) begin
      if (tick_i.cmd_valid) begin
        op_nxt         = tick_i.opcode;
        shift_nxt      = tick_i.tx_byte;
        ack_choice_nxt = tick_i.send_ack;
        phase_nxt      = '0;
        busy_nxt       = 1'b1;
        if (new_step.act != ACT_END) begin
          if (new_step.act == ACT_SCL) begin
            scl_nxt = new_step.lvl;
          end else if (new_step.act == ACT_SDA) begin
            sda_nxt = new_step.lvl;
          end
          hold_cnt_nxt = hold_eff;
        end
      end
    end else begin
      hold_cnt_nxt = hold_dec;
      if (hold_dec == '0) begin
        if (cur_step.act == ACT_SAMPLE) begin
          if (op_r == OP_WRITE) begin
            ack_level_nxt = tick_i.sda_in;
          end else begin
            shift_nxt = {shift_r[ByteW-2:0], tick_i.sda_in};
          end
        end
        phase_nxt = phase_inc;
        new_step  = step_decode(op_r, phase_inc, shift_nxt, ack_choice_r);
        if (new_step.act == ACT_END) begin
          if (op_r == OP_READ) begin
            rx_byte_nxt = shift_nxt;
          end
          busy_nxt  = 1'b0;
          phase_nxt = '0;
          done_nxt  = 1'b1;
        end else begin
          if (new_step.act == ACT_SCL) begin
            scl_nxt = new_step.lvl;
          end else if (new_step.act == ACT_SDA) begin
            sda_nxt = new_step.lvl;
          end
          hold_cnt_nxt = hold_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r         <= OP_START;
      busy_r       <= 1'b0;
      phase_r      <= '0;
      hold_cnt_r   <= '0;
      shift_r      <= '0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      rx_byte_r    <= '0;
      ack_level_r  <= 1'b1;
      done_r       <= 1'b0;
    end else if (tick_i.tick) begin
      op_r         <= op_nxt;
      busy_r       <= busy_nxt;
      phase_r      <= phase_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      shift_r      <= shift_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      rx_byte_r    <= rx_byte_nxt;
      ack_level_r  <= ack_level_nxt;
      done_r       <= done_nxt;
    end
  end

  assign status_o.scl       = scl_r;
  assign status_o.sda       = sda_r;
  assign status_o.busy      = busy_r;
  assign status_o.done      = done_r;
  assign status_o.rx_byte   = rx_byte_r;
  assign status_o.ack_level = ack_level_r;

  // A finished command is never reported as still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("done raised while busy");

  // Busy only drops together with the done pulse.
  a_busy_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy_r)) |-> done_r)
    else $error("busy dropped without done");

  // Every running step holds for at least one tick.
  a_hold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (hold_cnt_r != '0))
    else $error("hold counter empty while busy");

  // No command list is longer than 28 steps.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (phase_r <= PhaseW'(27)))
    else $error("step index out of range");

endmodule

// ===== hw/rtl/i2c_master_bit_sequencer.sv =====
// Top level of the I2C master line sequencer: word handshake, result register and APB register.
// The result word for an accepted input word is valid on the cycle after acceptance.
// Throughput: one input word per cycle while out_ready is high; the sequencer state, which is
// also the result register, advances once per accepted word.
// Reset (rst_n low, synchronous): both lines released, sequencer idle, hold_ticks back to 5,
// rx_byte 0, ack_level 1, no result word pending.
module i2c_master_bit_sequencer
  import i2cms_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  // Input word channel: one word is one bus tick.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd_valid,
  input  logic [1:0]          in_opcode,
  input  logic [ByteW-1:0]    in_tx_byte,
  input  logic                in_send_ack,
  input  logic                in_sda_in,

  // Result word channel: the line and status view after each tick.
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_scl_out,
  output logic                out_sda_out,
  output logic                out_busy_res,
  output logic                out_done_res,
  output logic [ByteW-1:0]    out_rx_byte,
  output logic                out_ack_level,

  // Register port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic             out_valid_r, out_valid_nxt;
  logic [HoldW-1:0] hold_ticks_r, hold_ticks_nxt;
  logic             accept;
  logic             reg_sel;
  tick_t            tick;
  status_t          status;

  // The state registers in the core double as the result register, so a new word can be
  // taken whenever the pending result is being consumed in the same cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // hold_ticks is the only register; it sits at word address zero (byte addresses 0 to 3).
  assign reg_sel = (paddr[ApbAddrW-1:2] == REG_HOLD_TICKS);

  always_comb begin
    hold_ticks_nxt = hold_ticks_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      hold_ticks_nxt = pwdata[HoldW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_ticks_r <= HOLD_RESET;
    end else begin
      out_valid_r  <= out_valid_nxt;
      hold_ticks_r <= hold_ticks_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_sel ? {{(ApbDataW-HoldW){1'b0}}, hold_ticks_r} : '0;

  assign tick.tick      = accept;
  assign tick.cmd_valid = in_cmd_valid;
  assign tick.opcode    = op_t'(in_opcode);
  assign tick.tx_byte   = in_tx_byte;
  assign tick.send_ack  = in_send_ack;
  assign tick.sda_in    = in_sda_in;

  i2cms_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_i       (tick),
    .hold_ticks_i (hold_ticks_r),
    .status_o     (status)
  );

  assign out_valid     = out_valid_r;
  assign out_scl_out   = status.scl;
  assign out_sda_out   = status.sda;
  assign out_busy_res  = status.busy;
  assign out_done_res  = status.done;
  assign out_rx_byte   = status.rx_byte;
  assign out_ack_level = status.ack_level;

endmodule
